FILE: rtl/mce_pkg.sv
// Shared types and constants for the matrix chain cost evaluator.
// No dependencies; every rtl file but mce_ram imports this package.
package mce_pkg;

    localparam int DIM_W  = 16;
    localparam int COST_W = 48;
    localparam int SYM_W  = 8;
    localparam int LET_W  = 5;

    localparam logic [SYM_W-1:0] SYM_OPEN     = 8'h28;
    localparam logic [SYM_W-1:0] SYM_CLOSE    = 8'h29;
    localparam logic [SYM_W-1:0] SYM_LETTER_A = 8'h41;
    localparam int               LETTER_COUNT = 26;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    // command field codes
    localparam logic CMD_DEFINE = 1'b0;
    localparam logic CMD_SYMBOL = 1'b1;

    // operation kinds handed from front to back
    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [KIND_W-1:0] OP_CLOSE = 2'd1;
    localparam logic [KIND_W-1:0] OP_BAD   = 2'd2;

    // op queue depth
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = 3;

    typedef struct packed {
        logic             command;
        logic [LET_W-1:0] letter;
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] cols;
        logic [SYM_W-1:0] symbol;
        logic             last;
    } in_t;

    typedef struct packed {
        logic              error;
        logic [COST_W-1:0] mult_count;
        logic              saturated;
    } out_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [DIM_W-1:0]  rows;
        logic [DIM_W-1:0]  cols;
        logic              last;
    } op_t;

    typedef struct packed {
        logic [DIM_W-1:0]  rows;
        logic [DIM_W-1:0]  cols;
        logic [COST_W-1:0] cost;
    } stack_entry_t;

endpackage

FILE: rtl/mce_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/mce_queue.sv
// Short FIFO of decoded operations between front and back.
// Depends on mce_pkg.
module mce_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  mce_pkg::op_t  push_op,
    output logic          full,
    input  logic          pop,
    output mce_pkg::op_t  pop_op,
    output logic          empty
);
    import mce_pkg::*;

    op_t             slot_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0] count_reg, count_next;

    assign full   = (count_reg == Q_CW'(Q_DEPTH));
    assign empty  = (count_reg == '0);
    assign pop_op = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + Q_AW'(push);
        rd_ptr_next = rd_ptr_reg + Q_AW'(pop);
        count_next  = count_reg + Q_CW'(push) - Q_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

FILE: rtl/mce_front.sv
// Front end: accepts items, keeps the letter dimension table, decodes symbols.
// Depends on mce_pkg.
module mce_front #(
    parameter int TABLE_ENTRIES = 26
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  mce_pkg::in_t  s_data,
    output logic          q_push,
    output mce_pkg::op_t  q_op,
    input  logic          q_full
);
    import mce_pkg::*;

    logic [DIM_W-1:0] dim_rows_reg [TABLE_ENTRIES];
    logic [DIM_W-1:0] dim_cols_reg [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] dim_valid_reg, dim_valid_next;
    logic [TABLE_ENTRIES-1:0] dim_we;

    logic             accept;
    logic [SYM_W-1:0] idx;
    logic             hit;
    logic [DIM_W-1:0] hit_rows, hit_cols;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign idx     = s_data.symbol - SYM_LETTER_A;

    // first definition of a letter wins
    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            dim_we[i] = accept && (s_data.command == CMD_DEFINE)
                        && (s_data.letter == LET_W'(i)) && !dim_valid_reg[i];
        end
        dim_valid_next = dim_valid_reg | dim_we;
    end

    always_comb begin
        hit      = 1'b0;
        hit_rows = '0;
        hit_cols = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (idx == SYM_W'(i) && dim_valid_reg[i]) begin
                hit      = 1'b1;
                hit_rows = dim_rows_reg[i];
                hit_cols = dim_cols_reg[i];
            end
        end
    end

    always_comb begin
        q_push      = accept && (s_data.command == CMD_SYMBOL);
        q_op.last   = s_data.last;
        q_op.rows   = '0;
        q_op.cols   = '0;
        if (s_data.symbol == SYM_OPEN) begin
            q_op.kind = OP_PUSH;
        end else if (s_data.symbol == SYM_CLOSE) begin
            q_op.kind = OP_CLOSE;
        end else if (s_data.symbol >= SYM_LETTER_A && hit) begin
            q_op.kind = OP_PUSH;
            q_op.rows = hit_rows;
            q_op.cols = hit_cols;
        end else begin
            q_op.kind = OP_BAD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_valid_reg <= '0;
        end else begin
            dim_valid_reg <= dim_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (dim_we[i]) begin
                dim_rows_reg[i] <= s_data.rows;
                dim_cols_reg[i] <= s_data.cols;
            end
        end
    end

endmodule

FILE: rtl/mce_back.sv
// Back end: evaluation stack (top entry in flops, the rest in RAM),
// combine datapath and result register. Depends on mce_pkg and mce_ram.
module mce_back #(
    parameter int STACK_DEPTH = 256
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_empty,
    input  mce_pkg::op_t  q_op,
    output logic          q_pop,
    output logic          m_valid,
    input  logic          m_ready,
    output mce_pkg::out_t m_data
);
    import mce_pkg::*;

    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int LVL_W = $clog2(STACK_DEPTH + 1);
    localparam int SUM_W = COST_W + 2;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_MUL    = 3'd2;
    localparam logic [2:0] ST_ADD    = 3'd3;
    localparam logic [2:0] ST_REPORT = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [LVL_W-1:0] level_reg, level_next;
    logic             failed_reg, failed_next;
    logic             overflow_reg, overflow_next;
    logic             last_reg, last_next;
    stack_entry_t     top_reg, top_next;
    logic [DIM_W-1:0] lt_rows_reg, lt_rows_next;
    logic [COST_W-1:0] lt_cost_reg, lt_cost_next;
    logic [2*DIM_W-1:0] prod1_reg, prod1_next;
    logic [COST_W-1:0] prod2_reg, prod2_next;
    logic             m_valid_reg, m_valid_next;
    out_t             out_reg, out_next;

    logic             ram_we, ram_re;
    stack_entry_t     ram_rdata;
    logic [SUM_W-1:0] sum;
    logic             sum_sat;
    logic             slot_free;
    logic             bad;

    mce_ram #(
        .WIDTH ($bits(stack_entry_t)),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (AW'(level_reg - LVL_W'(1))),
        .wdata (top_reg),
        .re    (ram_re),
        .raddr (AW'(level_reg - LVL_W'(2))),
        .rdata (ram_rdata)
    );

    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;
    assign slot_free = !m_valid_reg || m_ready;

    assign sum = SUM_W'(lt_cost_reg) + SUM_W'(top_reg.cost) + SUM_W'(prod2_reg);
    assign sum_sat = (sum > SUM_W'(COST_MAX));
    assign bad = failed_reg || (level_reg != LVL_W'(1));

    always_comb begin
        state_next    = state_reg;
        level_next    = level_reg;
        failed_next   = failed_reg;
        overflow_next = overflow_reg;
        last_next     = last_reg;
        top_next      = top_reg;
        lt_rows_next  = lt_rows_reg;
        lt_cost_next  = lt_cost_reg;
        prod1_next    = prod1_reg;
        prod2_next    = prod2_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        out_next      = out_reg;
        q_pop         = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    last_next  = q_op.last;
                    state_next = q_op.last ? ST_REPORT : ST_IDLE;
                    if (!failed_reg) begin
                        case (q_op.kind)
                            OP_PUSH: begin
                                if (level_reg == LVL_W'(STACK_DEPTH)) begin
                                    failed_next = 1'b1;
                                end else begin
                                    // spill the old top below the new one
                                    ram_we      = (level_reg != '0);
                                    top_next    = '{rows: q_op.rows, cols: q_op.cols,
                                                    cost: '0};
                                    level_next  = level_reg + LVL_W'(1);
                                end
                            end
                            OP_CLOSE: begin
                                if (level_reg < LVL_W'(3)) begin
                                    failed_next = 1'b1;
                                end else begin
                                    ram_re     = 1'b1;
                                    state_next = ST_READ;
                                end
                            end
                            default: begin
                                failed_next = 1'b1;
                            end
                        endcase
                    end
                end
            end
            ST_READ: begin
                // ram_rdata is the left operand, top_reg the right one
                if (ram_rdata.cols != top_reg.rows) begin
                    failed_next = 1'b1;
                    state_next  = last_reg ? ST_REPORT : ST_IDLE;
                end else begin
                    lt_rows_next = ram_rdata.rows;
                    lt_cost_next = ram_rdata.cost;
                    prod1_next   = (2*DIM_W)'(ram_rdata.rows) * (2*DIM_W)'(ram_rdata.cols);
                    state_next   = ST_MUL;
                end
            end
            ST_MUL: begin
                prod2_next = COST_W'(prod1_reg) * COST_W'(top_reg.cols);
                state_next = ST_ADD;
            end
            ST_ADD: begin
                top_next      = '{rows: lt_rows_reg, cols: top_reg.cols,
                                  cost: sum_sat ? COST_MAX : sum[COST_W-1:0]};
                overflow_next = overflow_reg || sum_sat;
                level_next    = level_reg - LVL_W'(2);
                state_next    = last_reg ? ST_REPORT : ST_IDLE;
            end
            ST_REPORT: begin
                if (slot_free) begin
                    m_valid_next       = 1'b1;
                    out_next.error     = bad;
                    out_next.mult_count = bad ? '0 : top_reg.cost;
                    out_next.saturated = !bad && overflow_reg;
                    level_next         = '0;
                    failed_next        = 1'b0;
                    overflow_next      = 1'b0;
                    state_next         = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            level_reg    <= '0;
            failed_reg   <= 1'b0;
            overflow_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            level_reg    <= level_next;
            failed_reg   <= failed_next;
            overflow_reg <= overflow_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_reg    <= last_next;
        top_reg     <= top_next;
        lt_rows_reg <= lt_rows_next;
        lt_cost_reg <= lt_cost_next;
        prod1_reg   <= prod1_next;
        prod2_reg   <= prod2_next;
        out_reg     <= out_next;
    end

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= LVL_W'(STACK_DEPTH))
        else $error("stack level beyond depth");

    a_read_needs_three: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_READ |-> level_reg >= LVL_W'(3))
        else $error("combine started with fewer than three entries");

    a_report_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_REPORT && slot_free
        |=> m_valid_reg && level_reg == '0 && !failed_reg && !overflow_reg)
        else $error("report did not issue a result and clear the stack");

    a_error_zeroes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && out_reg.error |-> out_reg.mult_count == '0 && !out_reg.saturated)
        else $error("error result carries a count");

endmodule

FILE: rtl/matrix_chain_expression_cost.sv
// Top level of the matrix chain cost evaluator.
// Depends on mce_pkg, mce_front, mce_queue, mce_back (and mce_ram below it).
//
// Usage:
//  s_ channel (valid/ready) carries one in_t per request. command = define
//  stores rows/cols for a letter (first definition kept, no result).
//  command = symbol feeds '(' , ')' or a letter into the evaluation stack;
//  the symbol with last set produces exactly one out_t on the m_ channel:
//  error, or the total scalar multiplication count with a saturated flag.
//
//  Flow: the front decodes and table-looks-up each request in the cycle it
//  is accepted and drops an op into a 4-entry queue. The back end takes one
//  op per cycle for pushes and bad symbols while it is not busy with a ')' or
//  held in its report step; a ')' that can combine passes through a stack RAM
//  read, a rows*cols multiply, a multiply by the new cols and a 50-bit add with
//  clamp before the next op is taken. A result then goes through the report
//  step, which loads the output register and raises m_valid.
//
//  Reset (aresetn low, synchronous): letter table invalidated, queue and
//  stack emptied, no result pending. Stack RAM needs no clearing.
//  Receiver stall: the result sits in the output register; the back end holds
//  at its next report step, the queue fills and s_ready drops when it is full.
module matrix_chain_expression_cost #(
    parameter int STACK_DEPTH   = 256,
    parameter int TABLE_ENTRIES = 26
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  mce_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output mce_pkg::out_t m_data
);
    import mce_pkg::*;

    // front -> queue
    logic q_push;
    op_t  q_push_op;
    logic q_full;

    // queue -> back
    logic q_pop;
    op_t  q_pop_op;
    logic q_empty;

    mce_front #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_push  (q_push),
        .q_op    (q_push_op),
        .q_full  (q_full)
    );

    // decouples table lookup from the multi-cycle combine
    mce_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_op (q_push_op),
        .full    (q_full),
        .pop     (q_pop),
        .pop_op  (q_pop_op),
        .empty   (q_empty)
    );

    mce_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_op    (q_pop_op),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

FILE: sim/tb_matrix_chain_expression_cost.sv
// Testbench for matrix_chain_expression_cost: directed and random requests with a
// built-in cost predictor. Depends on rtl/mce_pkg.sv and the RTL of the block.
module tb_matrix_chain_expression_cost;
    timeunit 1ns;
    timeprecision 1ps;

    import mce_pkg::*;

    localparam int STACK_N        = 256;
    localparam int TABLE_N        = 26;
    localparam int RESET_CYCLES   = 7;
    localparam int RANDOM_SYMBOLS = 700;
    // Nothing accepted on either side for this many cycles means the block hung.
    // Worst legal quiet stretch is a long sender gap plus a long result stall plus
    // a few combine steps.
    localparam int STALL_LIMIT    = 2000;
    // Longest path from last symbol to result is a ')' combine plus a full op queue.
    localparam int DRAIN_CYCLES   = 40;

    // Letter table slots used by the directed part
    localparam logic [LET_W-1:0] LET_A = 5'd0;
    localparam logic [LET_W-1:0] LET_B = 5'd1;
    localparam logic [LET_W-1:0] LET_Z = 5'd25;
    // Random chains use a 3x3 grid of dimension pairs at letters C..K
    localparam int GRID_BASE = 2;
    localparam logic [SYM_W-1:0] SYM_LOWER_A = 8'h61;

    logic  aclk;
    logic  aresetn;
    logic  s_valid;
    logic  s_ready;
    in_t   s_data;
    logic  m_valid;
    logic  m_ready;
    out_t  m_data;

    matrix_chain_expression_cost #(
        .STACK_DEPTH  (STACK_N),
        .TABLE_ENTRIES(TABLE_N)
    ) DUT (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: letter table, evaluation stack and per-expression flags
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]  dim_rows_tbl [TABLE_N];
    logic [DIM_W-1:0]  dim_cols_tbl [TABLE_N];
    bit                dim_set      [TABLE_N];
    logic [DIM_W-1:0]  stk_rows     [STACK_N];
    logic [DIM_W-1:0]  stk_cols     [STACK_N];
    logic [COST_W-1:0] stk_cost     [STACK_N];
    int                stack_fill;
    bit                expr_failed;
    bit                expr_clamped;

    out_t pending_reports[$];   // expected results, oldest first
    int   fail_count;
    int   symbols_sent;
    bit   sender_steady;        // no gaps between requests while set
    int   quiet_cycles;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void push_dims(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] c);
        if (stack_fill >= STACK_N) begin
            expr_failed = 1'b1;
            return;
        end
        stk_rows[stack_fill] = r;
        stk_cols[stack_fill] = c;
        stk_cost[stack_fill] = '0;
        stack_fill++;
    endfunction

    // Advance the predicted state by one accepted request; queue a result on a symbol with last set.
    function automatic void evaluate_request(input in_t req);
        int          idx;
        int          lt;
        int          rt;
        logic [63:0] lr;
        logic [63:0] lc;
        logic [63:0] rc;
        logic [63:0] sum;
        bit          bad;
        out_t        rep;

        if (req.command == CMD_DEFINE) begin
            // out-of-range letters and redefinitions are dropped
            if (int'(req.letter) < TABLE_N && !dim_set[req.letter]) begin
                dim_rows_tbl[req.letter] = req.rows;
                dim_cols_tbl[req.letter] = req.cols;
                dim_set[req.letter]      = 1'b1;
            end
            return;
        end

        if (!expr_failed) begin
            if (req.symbol == SYM_OPEN) begin
                push_dims('0, '0);
            end else if (req.symbol == SYM_CLOSE) begin
                // needs marker + left + right on the stack
                if (stack_fill < 3) begin
                    expr_failed = 1'b1;
                end else begin
                    rt = stack_fill - 1;
                    lt = stack_fill - 2;
                    if (stk_cols[lt] != stk_rows[rt]) begin
                        expr_failed = 1'b1;
                    end else begin
                        lr  = 64'(stk_rows[lt]);
                        lc  = 64'(stk_cols[lt]);
                        rc  = 64'(stk_cols[rt]);
                        sum = {16'd0, stk_cost[lt]} + {16'd0, stk_cost[rt]} + lr * lc * rc;
                        if (sum > {16'd0, COST_MAX}) begin
                            sum          = {16'd0, COST_MAX};
                            expr_clamped = 1'b1;
                        end
                        stk_rows[stack_fill-3] = stk_rows[lt];
                        stk_cols[stack_fill-3] = stk_cols[rt];
                        stk_cost[stack_fill-3] = sum[COST_W-1:0];
                        stack_fill -= 2;
                    end
                end
            end else begin
                idx = int'(req.symbol) - int'(SYM_LETTER_A);
                if (idx < 0 || idx >= LETTER_COUNT || idx >= TABLE_N || !dim_set[idx])
                    expr_failed = 1'b1;
                else
                    push_dims(dim_rows_tbl[idx], dim_cols_tbl[idx]);
            end
        end

        if (req.last) begin
            bad            = expr_failed || stack_fill != 1;
            rep.error      = bad;
            rep.mult_count = bad ? '0 : stk_cost[0];
            rep.saturated  = !bad && expr_clamped;
            pending_reports.push_back(rep);
            stack_fill   = 0;
            expr_failed  = 1'b0;
            expr_clamped = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Request side. Every task starts and ends at a falling edge; valid is
    // only dropped when a gap follows, so it never bounces within a step.
    // ------------------------------------------------------------------
    task automatic send_request(input in_t req);
        int gap;
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        evaluate_request(req);
        @(negedge aclk);
    endtask

    task automatic send_define(input logic [LET_W-1:0] letter, input logic [DIM_W-1:0] r,
                               input logic [DIM_W-1:0] c, input logic is_last);
        in_t req;
        req.command = CMD_DEFINE;
        req.letter  = letter;
        req.rows    = r;
        req.cols    = c;
        req.symbol  = SYM_W'($urandom_range(0, 255));
        req.last    = is_last;
        send_request(req);
    endtask

    task automatic send_random_define();
        send_define(LET_W'($urandom_range(0, 31)), DIM_W'($urandom_range(0, 65535)),
                    DIM_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
    endtask

    // Symbol requests carry random junk in the define-only fields.
    task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic is_last);
        in_t req;
        req.command = CMD_SYMBOL;
        req.letter  = LET_W'($urandom_range(0, 31));
        req.rows    = DIM_W'($urandom_range(0, 65535));
        req.cols    = DIM_W'($urandom_range(0, 65535));
        req.symbol  = sym;
        req.last    = is_last;
        symbols_sent++;
        send_request(req);
    endtask

    task automatic send_expression(input string text);
        for (int k = 0; k < text.len(); k++)
            send_symbol(text[k], k == text.len() - 1);
    endtask

    // Symbol run with the odd define request mixed in mid-expression
    task automatic send_symbol_run(input logic [SYM_W-1:0] syms[$]);
        foreach (syms[k]) begin
            if ($urandom_range(0, 29) == 0)
                send_random_define();
            send_symbol(syms[k], k == syms.size() - 1);
        end
    endtask

    // Fully parenthesized chain of n grid matrices with matching inner dims,
    // built top-down from a work list; sometimes corrupted at one spot.
    task automatic send_chain(input int n);
        int               dims[$];
        int               work[$];
        logic [SYM_W-1:0] syms[$];
        int               cnt;
        int               left;
        int               pos;
        int               at;
        int               code;

        for (int k = 0; k <= n; k++)
            dims.push_back($urandom_range(0, 2));
        pos = 0;
        work.push_back(n);
        while (work.size() != 0) begin
            cnt = work.pop_back();
            if (cnt == 0) begin
                syms.push_back(SYM_CLOSE);      // 0 marks a pending close
            end else if (cnt == 1) begin
                code = int'(SYM_LETTER_A) + GRID_BASE + 3 * dims[pos] + dims[pos+1];
                syms.push_back(code[SYM_W-1:0]);
                pos++;
            end else begin
                left = $urandom_range(1, cnt - 1);
                syms.push_back(SYM_OPEN);
                work.push_back(0);
                work.push_back(cnt - left);
                work.push_back(left);
            end
        end

        if ($urandom_range(0, 99) < 15) begin
            at = $urandom_range(0, syms.size() - 1);
            case ($urandom_range(0, 3))
                0: syms[at] = SYM_W'($urandom_range(0, 255));
                1: begin
                    syms.delete(at);
                    if (syms.size() == 0)
                        syms.push_back(SYM_W'(SYM_LETTER_A + $urandom_range(0, 25)));
                end
                2: begin
                    code     = int'(SYM_LETTER_A) + GRID_BASE + $urandom_range(0, 8);
                    syms[at] = code[SYM_W-1:0];
                end
                default: syms.insert(at, SYM_CLOSE);
            endcase
        end
        send_symbol_run(syms);
    endtask

    task automatic send_noise(input int n);
        logic [SYM_W-1:0] syms[$];
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 4))
                0:       syms.push_back(SYM_OPEN);
                1:       syms.push_back(SYM_CLOSE);
                2:       syms.push_back(SYM_W'(SYM_LETTER_A + $urandom_range(0, 25)));
                3:       syms.push_back(SYM_W'(SYM_LOWER_A + $urandom_range(0, 25)));
                default: syms.push_back(SYM_W'($urandom_range(0, 255)));
            endcase
        end
        send_symbol_run(syms);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Extreme dims, a zero matrix, a redefinition, out-of-range letters,
    // and last set on a define (must not produce a result).
    task automatic test_table_defines();
        send_define(LET_A, 16'hFFFF, 16'hFFFF, 1'b0);
        send_define(LET_B, 16'hFFFF, 16'hFFFF, 1'b0);
        send_define(LET_Z, 16'h0000, 16'h0000, 1'b1);
        send_define(LET_A, 16'h0001, 16'h0001, 1'b0);
        send_define(5'd26, 16'h0005, 16'h0005, 1'b0);
        send_define(5'd31, 16'h0007, 16'h0007, 1'b1);
    endtask

    task automatic test_directed_expressions();
        send_expression("A");           // lone matrix, zero cost
        send_expression("(AB)");        // largest single product, still fits
        send_expression("((AB)B)");     // sum goes past 48 bits, clamps
        send_expression("(AZ)");        // inner dims differ
        send_expression(")");           // close on an empty stack
        send_expression("(A)");         // close with only one operand
        send_expression("M");           // letter never defined
        send_symbol(8'hFF, 1'b1);       // not a letter at all
        send_expression("QA(");         // symbols after a failure are ignored
        send_expression("(");           // bare marker leaves one entry: good
        send_expression("(ZZ)");        // zero-sized matrices
    endtask

    // One push past the stack depth.
    task automatic test_stack_overflow();
        string text;
        text = "";
        repeat (STACK_N + 1) text = {text, "("};
        send_expression(text);
    endtask

    task automatic test_random_chains();
        logic [DIM_W-1:0] grid_dim[3];
        int               goal;
        int               action;

        // one small, one medium, one large dimension so long chains can clamp
        grid_dim[0] = DIM_W'($urandom_range(1, 16));
        grid_dim[1] = DIM_W'($urandom_range(17, 2000));
        grid_dim[2] = DIM_W'($urandom_range(2001, 65535));
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                send_define(LET_W'(GRID_BASE + 3 * i + j), grid_dim[i], grid_dim[j],
                            1'($urandom_range(0, 1)));

        goal = symbols_sent + RANDOM_SYMBOLS;
        while (symbols_sent < goal) begin
            sender_steady = ($urandom_range(0, 6) == 0);
            action        = $urandom_range(0, 99);
            if (action < 85)
                send_chain(($urandom_range(0, 4) == 0) ? $urandom_range(7, 40)
                                                       : $urandom_range(1, 6));
            else if (action < 95)
                send_noise($urandom_range(1, 6));
            else
                send_random_define();
        end
        sender_steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: m_ready stalls come in phases, some with no stalls at all.
    // ------------------------------------------------------------------
    initial begin : drive_result_ready
        int stall_left;
        int phase_left;
        bit may_stall;
        m_ready    = 1'b0;
        stall_left = 0;
        phase_left = 0;
        may_stall  = 1'b1;
        forever begin
            @(negedge aclk);
            if (phase_left == 0) begin
                may_stall  = ($urandom_range(0, 3) != 0);
                phase_left = $urandom_range(50, 300);
            end
            phase_left--;
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (may_stall && $urandom_range(0, 5) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Compare each delivered result with the oldest prediction.
    always @(posedge aclk) begin : check_reports
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_reports.size() == 0) begin
                $error("unexpected result: error=%0d mult_count=%0h saturated=%0d",
                       m_data.error, m_data.mult_count, m_data.saturated);
                fail_count++;
            end else begin
                want = pending_reports.pop_front();
                if (m_data.error !== want.error) begin
                    $error("error: expected %0d, got %0d", want.error, m_data.error);
                    fail_count++;
                end
                if (m_data.mult_count !== want.mult_count) begin
                    $error("mult_count: expected %0h, got %0h",
                           want.mult_count, m_data.mult_count);
                    fail_count++;
                end
                if (m_data.saturated !== want.saturated) begin
                    $error("saturated: expected %0d, got %0d",
                           want.saturated, m_data.saturated);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: any accepted request on either side resets the count.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : run_tests
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        fail_count    = 0;
        symbols_sent  = 0;
        sender_steady = 1'b0;
        quiet_cycles  = 0;
        stack_fill    = 0;
        expr_failed   = 1'b0;
        expr_clamped  = 1'b0;
        for (int k = 0; k < TABLE_N; k++) begin
            dim_rows_tbl[k] = '0;
            dim_cols_tbl[k] = '0;
            dim_set[k]      = 1'b0;
        end

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_table_defines();
        test_directed_expressions();
        test_stack_overflow();
        test_random_chains();
        s_valid <= 1'b0;

        // drain; the watchdog covers a block that never answers
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pending_reports.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: matrix_chain_expression_cost.f
rtl/mce_pkg.sv
rtl/mce_ram.sv
rtl/mce_queue.sv
rtl/mce_front.sv
rtl/mce_back.sv
rtl/matrix_chain_expression_cost.sv
sim/tb_matrix_chain_expression_cost.sv
